/* design/gwlr_pkg.sv */
// ----------------------------------------------------------------------------
// gwlr_pkg
// Shared types, constants and saturation helper for the groundwater
// linear reservoir step block.
// ----------------------------------------------------------------------------
package gwlr_pkg;

    // grid size and index widths
    localparam int CELLS      = 4096;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int CELL_IDX_W = 12;

    // q16.16 data and config widths
    localparam int DATA_W      = 32;
    localparam int WIDE_W      = DATA_W + 2;
    localparam int BETA_W      = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int PROD_W      = DATA_W + BETA_W + 1;
    localparam int FRAC_W      = 16;

    // reset value of the drain coefficient, about 1/60 in q0.16
    localparam logic [BETA_W-1:0] BETA_RESET = 16'd1092;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRAIN_COEF   = 8'd0,
        CFG_IRR_EN       = 8'd1,
        CFG_POND_EN      = 8'd2,
        CFG_GW_IRR_EN    = 8'd3
    } t_cfg_reg;

    // storage write request
    typedef struct packed {
        logic                     valid;
        logic [CELL_W-1:0]        addr;
        logic signed [DATA_W-1:0] data;
    } t_wr_req;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // clamp a widened signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > WIDE_W'(SAT_MAX)) begin
            res = SAT_MAX;
        end else if (v < WIDE_W'(SAT_MIN)) begin
            res = SAT_MIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

/* design/gwlr_item_if.sv */
// ----------------------------------------------------------------------------
// gwlr_item_if
// Input channel: one grid cell and its fluxes per item.
// ----------------------------------------------------------------------------
interface gwlr_item_if import gwlr_pkg::*; ;
    logic                         valid;
    logic                         ready;
    logic        [CELL_IDX_W-1:0] cell_index;
    logic signed [DATA_W-1:0]     recharge;
    logic signed [DATA_W-1:0]     return_flow;
    logic signed [DATA_W-1:0]     irrigation_runoff;
    logic signed [DATA_W-1:0]     gross_demand;
    logic signed [DATA_W-1:0]     pond_release;

    modport source (
        output valid, cell_index, recharge, return_flow, irrigation_runoff,
               gross_demand, pond_release,
        input  ready
    );
    modport sink (
        input  valid, cell_index, recharge, return_flow, irrigation_runoff,
               gross_demand, pond_release,
        output ready
    );
endinterface

/* design/gwlr_result_if.sv */
// ----------------------------------------------------------------------------
// gwlr_result_if
// Result channel: updated storage and the step's flux totals per item.
// ----------------------------------------------------------------------------
interface gwlr_result_if import gwlr_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_storage;
    logic signed [DATA_W-1:0] storage_change;
    logic signed [DATA_W-1:0] total_recharge;
    logic signed [DATA_W-1:0] total_uptake;
    logic signed [DATA_W-1:0] base_flow;
    logic signed [DATA_W-1:0] groundwater_irrigation;
    logic signed [DATA_W-1:0] external_irrigation;

    modport source (
        output valid, new_storage, storage_change, total_recharge, total_uptake,
               base_flow, groundwater_irrigation, external_irrigation,
        input  ready
    );
    modport sink (
        input  valid, new_storage, storage_change, total_recharge, total_uptake,
               base_flow, groundwater_irrigation, external_irrigation,
        output ready
    );
endinterface

/* design/gwlr_cfg_if.sv */
// ----------------------------------------------------------------------------
// gwlr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gwlr_cfg_if import gwlr_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/groundwater_linear_reservoir_step.sv */
// ----------------------------------------------------------------------------
// groundwater_linear_reservoir_step
// Linear reservoir groundwater update, one grid cell per item, with storage
// held in an on-chip memory and an eight-stage arithmetic pipeline.
//
//   channel    dir  handshake             contents
//   i_item     in   valid / ready         cell index and five q16.16 fluxes
//   o_result   out  valid / ready         seven q16.16 results
//   i_cfg      in   valid / ready (=1)    register index and write data
//
// One item per cycle, unless a result stall, a cell hazard or the clear sweep
// holds the input; a result is offered from the stage 8 register. An item
// whose cell is still in flight in stages 1 to 6 (read through write-back)
// waits until that write lands. After reset a zero-fill sweep clears all
// 4096 storage cells, taking no item; config writes are taken at any time.
// A stalled result holds the pipeline from the back; empty stages still fill.
// ----------------------------------------------------------------------------
module groundwater_linear_reservoir_step import gwlr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gwlr_item_if.sink     i_item,
    gwlr_result_if.source o_result,
    gwlr_cfg_if.sink      i_cfg
);

    // configuration registers
    logic [BETA_W-1:0] r_beta;
    logic              r_irr_en;
    logic              r_pond_en;
    logic              r_gw_irr_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta      <= BETA_RESET;
            r_irr_en    <= 1'b0;
            r_pond_en   <= 1'b0;
            r_gw_irr_en <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DRAIN_COEF: r_beta      <= i_cfg.data[BETA_W-1:0];
                CFG_IRR_EN:     r_irr_en    <= i_cfg.data[0];
                CFG_POND_EN:    r_pond_en   <= i_cfg.data[0];
                CFG_GW_IRR_EN:  r_gw_irr_en <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // stage valids and ready chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

    assign rdy8 = !r_v8 || o_result.ready;
    assign rdy7 = !r_v7 || rdy8;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    // pipeline payload registers
    logic [CELL_W-1:0]        r1_cell, r2_cell, r3_cell, r4_cell, r5_cell, r6_cell;
    logic signed [DATA_W-1:0] r1_rech, r1_rflow, r1_roff, r1_demand, r1_pond;
    logic signed [DATA_W-1:0] r2_old, r3_old, r4_old, r5_old, r6_old, r7_old;
    logic signed [DATA_W-1:0] r2_gw, r3_gw, r4_gw, r5_gw, r6_gw;
    logic signed [DATA_W:0]   r2_rfro;
    logic signed [DATA_W-1:0] r2_trech, r3_trech, r4_trech, r5_trech, r6_trech, r7_trech;
    logic signed [DATA_W-1:0] r2_dnet, r3_dnet;
    logic signed [DATA_W-1:0] r4_gwi, r5_gwi, r6_gwi, r7_gwi;
    logic signed [DATA_W-1:0] r4_ext, r5_ext, r6_ext, r7_ext;
    logic signed [PROD_W-1:0] r5_prod;
    logic signed [DATA_W-1:0] r6_base, r7_base;
    logic signed [DATA_W-1:0] r7_newst, r7_uptake;

    // output register
    logic signed [DATA_W-1:0] r8_newst, r8_change, r8_trech, r8_uptake;
    logic signed [DATA_W-1:0] r8_base, r8_gwi, r8_ext;

    // storage memory
    logic                     clearing;
    logic signed [DATA_W-1:0] rd_data;
    t_wr_req                  wr_req;
    logic [CELL_W-1:0]        in_cell;
    logic                     hazard;
    logic                     accept;

    assign in_cell = i_item.cell_index[CELL_W-1:0];

    // interlock: cell still between read and write-back
    assign hazard = (r_v1 && r1_cell == in_cell) || (r_v2 && r2_cell == in_cell)
                 || (r_v3 && r3_cell == in_cell) || (r_v4 && r4_cell == in_cell)
                 || (r_v5 && r5_cell == in_cell) || (r_v6 && r6_cell == in_cell);

    assign i_item.ready = rdy1 && !hazard && !clearing;
    assign accept       = i_item.valid && i_item.ready;

    gwlr_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (in_cell),
        .i_wr       (wr_req),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    // stage 2: clamp old storage, add recharge, net demand
    logic signed [DATA_W-1:0] s2_old, s2_gw, s2_trech, s2_dnet;
    logic signed [DATA_W:0]   s2_rfro;
    always_comb begin
        s2_old   = rd_data[DATA_W-1] ? '0 : rd_data;
        s2_gw    = sat32(WIDE_W'(s2_old) + WIDE_W'(r1_rech));
        s2_rfro  = (DATA_W+1)'(r1_rflow) + (DATA_W+1)'(r1_roff);
        s2_trech = r_irr_en ? sat32(WIDE_W'(r1_rech) + WIDE_W'(s2_rfro)) : r1_rech;
        s2_dnet  = (r_irr_en && r_pond_en)
                 ? sat32(WIDE_W'(r1_demand) - WIDE_W'(r1_pond)) : r1_demand;
    end

    // stage 3: add return flow and runoff when irrigation is enabled
    logic signed [DATA_W-1:0] s3_gw;
    assign s3_gw = r_irr_en ? sat32(WIDE_W'(r2_gw) + WIDE_W'(r2_rfro)) : r2_gw;

    // stage 4: split demand between groundwater and external supply
    logic signed [DATA_W-1:0] s4_gw, s4_gwi, s4_ext;
    always_comb begin
        s4_gw  = r3_gw;
        s4_gwi = '0;
        s4_ext = '0;
        if (r_irr_en) begin
            if (r_gw_irr_en) begin
                if (r3_dnet < r3_gw) begin
                    s4_gwi = r3_dnet;
                    s4_gw  = sat32(WIDE_W'(r3_gw) - WIDE_W'(r3_dnet));
                end else begin
                    s4_gwi = r3_gw;
                    s4_ext = sat32(WIDE_W'(r3_dnet) - WIDE_W'(r3_gw));
                    s4_gw  = '0;
                end
            end else begin
                s4_ext = r3_dnet;
            end
        end
    end

    // stage 5: storage times drain coefficient
    logic signed [PROD_W-1:0] s5_prod;
    assign s5_prod = PROD_W'(r4_gw) * PROD_W'($signed({1'b0, r_beta}));

    // stage 6: round to nearest, ties up
    logic signed [PROD_W:0]   s6_rnd;
    logic signed [DATA_W-1:0] s6_base;
    always_comb begin
        s6_rnd  = (PROD_W+1)'(r5_prod) + (PROD_W+1)'(1 << (FRAC_W - 1));
        s6_base = sat32(WIDE_W'(s6_rnd >>> FRAC_W));
    end

    // stage 7: drain and total uptake, write back storage
    logic signed [DATA_W-1:0] s7_newst, s7_uptake;
    always_comb begin
        s7_newst     = sat32(WIDE_W'(r6_gw) - WIDE_W'(r6_base));
        s7_uptake    = sat32(WIDE_W'(r6_base) + WIDE_W'(r6_gwi));
        wr_req.valid = r_v6 && rdy7;
        wr_req.addr  = r6_cell;
        wr_req.data  = s7_newst;
    end

    // stage 8: storage change
    logic signed [DATA_W-1:0] s8_change;
    assign s8_change = sat32(WIDE_W'(r7_newst) - WIDE_W'(r7_old));

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= accept;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
            if (rdy8) r_v8 <= r_v7;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_cell   <= in_cell;
            r1_rech   <= i_item.recharge;
            r1_rflow  <= i_item.return_flow;
            r1_roff   <= i_item.irrigation_runoff;
            r1_demand <= i_item.gross_demand;
            r1_pond   <= i_item.pond_release;
        end
        if (r_v1 && rdy2) begin
            r2_cell  <= r1_cell;
            r2_old   <= s2_old;
            r2_gw    <= s2_gw;
            r2_rfro  <= s2_rfro;
            r2_trech <= s2_trech;
            r2_dnet  <= s2_dnet;
        end
        if (r_v2 && rdy3) begin
            r3_cell  <= r2_cell;
            r3_old   <= r2_old;
            r3_gw    <= s3_gw;
            r3_trech <= r2_trech;
            r3_dnet  <= r2_dnet;
        end
        if (r_v3 && rdy4) begin
            r4_cell  <= r3_cell;
            r4_old   <= r3_old;
            r4_gw    <= s4_gw;
            r4_trech <= r3_trech;
            r4_gwi   <= s4_gwi;
            r4_ext   <= s4_ext;
        end
        if (r_v4 && rdy5) begin
            r5_cell  <= r4_cell;
            r5_old   <= r4_old;
            r5_gw    <= r4_gw;
            r5_trech <= r4_trech;
            r5_gwi   <= r4_gwi;
            r5_ext   <= r4_ext;
            r5_prod  <= s5_prod;
        end
        if (r_v5 && rdy6) begin
            r6_cell  <= r5_cell;
            r6_old   <= r5_old;
            r6_gw    <= r5_gw;
            r6_trech <= r5_trech;
            r6_gwi   <= r5_gwi;
            r6_ext   <= r5_ext;
            r6_base  <= s6_base;
        end
        if (r_v6 && rdy7) begin
            r7_old    <= r6_old;
            r7_trech  <= r6_trech;
            r7_gwi    <= r6_gwi;
            r7_ext    <= r6_ext;
            r7_base   <= r6_base;
            r7_newst  <= s7_newst;
            r7_uptake <= s7_uptake;
        end
        if (r_v7 && rdy8) begin
            r8_newst  <= r7_newst;
            r8_change <= s8_change;
            r8_trech  <= r7_trech;
            r8_uptake <= r7_uptake;
            r8_base   <= r7_base;
            r8_gwi    <= r7_gwi;
            r8_ext    <= r7_ext;
        end
    end

    // result channel
    assign o_result.valid                  = r_v8;
    assign o_result.new_storage            = r8_newst;
    assign o_result.storage_change         = r8_change;
    assign o_result.total_recharge         = r8_trech;
    assign o_result.total_uptake           = r8_uptake;
    assign o_result.base_flow              = r8_base;
    assign o_result.groundwater_irrigation = r8_gwi;
    assign o_result.external_irrigation    = r8_ext;

endmodule

/* design/gwlr_store.sv */
// ----------------------------------------------------------------------------
// gwlr_store
// Per-cell storage memory with one read and one write port, registered read
// data, and a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module gwlr_store import gwlr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [CELL_W-1:0]        i_rd_addr,
    input  t_wr_req                  i_wr,
    output logic signed [DATA_W-1:0] o_rd_data,
    output logic                     o_clearing
);

    logic signed [DATA_W-1:0] mem [CELLS];
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_clearing;
    logic [CELL_W-1:0]        r_clr_addr;

    logic                     wr_en;
    logic [CELL_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    // sweep owns the write port until every cell is zero
    always_comb begin
        wr_en   = r_clearing | i_wr.valid;
        wr_addr = r_clearing ? r_clr_addr : i_wr.addr;
        wr_data = r_clearing ? '0 : i_wr.data;
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CELL_W'(CELLS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // memory array, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule
